FILE: hdl/tcfd_pkg.sv
// ----------------------------------------------------------------------------
// tcfd_pkg: shared types and constants for the text cell frame store
// Opcodes, register indexes, glyph codes and the command word that travels
// from the front end through the command queue into the cell engine.
// ----------------------------------------------------------------------------
package tcfd_pkg;

  localparam int unsigned POS_W     = 9;
  localparam int unsigned CUR_W     = 10;
  localparam int unsigned GLYPH_W   = 8;
  localparam int unsigned COLOR_W   = 3;
  localparam int unsigned RW_W      = 8;   // rect_width field
  localparam int unsigned RH_W      = 7;   // rect_height field
  localparam int unsigned SCOLS_W   = 8;   // screen_cols register
  localparam int unsigned SROWS_W   = 7;   // screen_rows register
  localparam int unsigned OUT_ROW_W = 6;
  localparam int unsigned OUT_COL_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  // Widest cell coordinates over the allowed frame sizes
  localparam int unsigned COL_FW    = 8;
  localparam int unsigned ROW_FW    = 7;

  localparam logic [GLYPH_W-1:0]     GLYPH_NEWLINE = 8'd10;
  localparam logic [GLYPH_W-1:0]     GLYPH_SPACE   = 8'h20;
  localparam logic [GLYPH_W-1:0]     GLYPH_NULL    = 8'h00;
  localparam logic [COLOR_W-1:0]     COLOR_DEFAULT = 3'd0;
  localparam logic signed [CUR_W-1:0] CURSOR_MAX   = 10'sd511;
  localparam logic [SCOLS_W-1:0]     COLS_RESET    = 8'd80;
  localparam logic [SROWS_W-1:0]     ROWS_RESET    = 7'd24;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_ORIGIN = 3'd1,
    OP_TEXT   = 3'd2,
    OP_RECT   = 3'd3,
    OP_SCAN   = 3'd4,
    OP_INVAL  = 3'd5
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLS = 2'd0,
    REG_ROWS = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_WR_CHAR   = 3'd0,
    CMD_RECT      = 3'd1,
    CMD_SCAN      = 3'd2,
    CMD_CLR_NEXT  = 3'd3,
    CMD_CLR_SHOWN = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e                kind;
    logic [COL_FW-1:0]   col;       // cell column, or rectangle first column
    logic [ROW_FW-1:0]   row;       // cell row, or rectangle first row
    logic [COL_FW-1:0]   col_last;  // rectangle last column
    logic [ROW_FW-1:0]   row_last;  // rectangle last row
    logic [GLYPH_W-1:0]  glyph;
    logic [COLOR_W-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic [COLOR_W-1:0]   color;
    logic [GLYPH_W-1:0]   glyph;
  } res_t;

  typedef struct packed {
    logic clr_next;
    logic clr_shown_char;
    logic clr_shown_color;
  } sweep_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SWEEP = 2'd1,
    ST_RECT  = 2'd2,
    ST_SCAN  = 2'd3
  } bk_state_e;

endpackage

FILE: hdl/text_cell_framebuffer_delta.sv
// ----------------------------------------------------------------------------
// text_cell_framebuffer_delta: character cell frame store with delta scan-out
// Top level: configuration registers, decode front end, command queue and
// cell engine.
// ----------------------------------------------------------------------------
// Usage:
//   Operations enter on the command channel: an item is taken on a clock edge
//   with start_i high and busy_o low. busy_o rises when the two-entry command
//   queue is full and during the store clear after reset.
//   Cursor moves and origin changes finish in the accepting cycle. The engine
//   takes each command from the queue in its idle state: a character write
//   needs nothing more, a scan adds a compare-and-copy state, so text items
//   sustain one item per cycle while no scan, rectangle or sweep holds the
//   engine; the queue holds the next item meanwhile. A rectangle walks its
//   clipped cells one per cycle. Clear and invalidate sweep the whole store
//   one cell per cycle on the single write port, across all
//   2**(clog2(MAX_COLS)+clog2(MAX_ROWS)) cells, 8192 at the default size.
//   A changed cell appears as a one-cycle beat on cell_valid_o with row,
//   column, color and character, registered after the scan state compares
//   the cell. The receiver cannot hold results off; beats never come in
//   consecutive cycles.
//   After reset the engine sweeps both frames to spaces and color zero with
//   busy_o high. Registers reset to 80 columns by 24 rows; write them
//   through cfg_valid_i/cfg_ready_o only while idle.
// ----------------------------------------------------------------------------
module text_cell_framebuffer_delta #(
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [2:0]                          op_i,
  input  logic signed [tcfd_pkg::POS_W-1:0]   pos_x_i,
  input  logic signed [tcfd_pkg::POS_W-1:0]   pos_y_i,
  input  logic [tcfd_pkg::GLYPH_W-1:0]        glyph_i,
  input  logic [tcfd_pkg::RW_W-1:0]           rect_width_i,
  input  logic [tcfd_pkg::RH_W-1:0]           rect_height_i,
  input  logic [tcfd_pkg::COLOR_W-1:0]        paint_color_i,
  output logic                                cell_valid_o,
  output logic [tcfd_pkg::OUT_ROW_W-1:0]      cell_row_o,
  output logic [tcfd_pkg::OUT_COL_W-1:0]      cell_col_o,
  output logic [tcfd_pkg::COLOR_W-1:0]        cell_color_o,
  output logic [tcfd_pkg::GLYPH_W-1:0]        cell_char_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tcfd_pkg::SCOLS_W-1:0]        cfg_data_i
);
  import tcfd_pkg::*;

  logic [SCOLS_W-1:0] cols_q;
  logic [SROWS_W-1:0] rows_q;
  logic               accept, push, pop, q_empty, q_full, init;
  cmd_t               cmd, head;
  res_t               res;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = q_full || init;
  assign accept      = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_COLS: cols_q <= cfg_data_i;
        REG_ROWS: rows_q <= cfg_data_i[SROWS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcfd_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .op_i          (op_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .glyph_i       (glyph_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .paint_color_i (paint_color_i),
    .screen_cols_i (cols_q),
    .screen_rows_i (rows_q),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  tcfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tcfd_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .init_o      (init),
    .res_valid_o (cell_valid_o),
    .res_o       (res)
  );

  assign cell_row_o   = res.row;
  assign cell_col_o   = res.col;
  assign cell_color_o = res.color;
  assign cell_char_o  = res.glyph;

endmodule

FILE: hdl/tcfd_front.sv
// ----------------------------------------------------------------------------
// tcfd_front: operation decode and text cursor
// Classifies each accepted operation, keeps the text run cursor, clips
// rectangles and scans against the screen size, and issues cell commands.
// ----------------------------------------------------------------------------
module tcfd_front #(
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [2:0]                        op_i,
  input  logic signed [tcfd_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [tcfd_pkg::POS_W-1:0] pos_y_i,
  input  logic [tcfd_pkg::GLYPH_W-1:0]      glyph_i,
  input  logic [tcfd_pkg::RW_W-1:0]         rect_width_i,
  input  logic [tcfd_pkg::RH_W-1:0]         rect_height_i,
  input  logic [tcfd_pkg::COLOR_W-1:0]      paint_color_i,
  input  logic [tcfd_pkg::SCOLS_W-1:0]      screen_cols_i,
  input  logic [tcfd_pkg::SROWS_W-1:0]      screen_rows_i,
  output logic                              push_o,
  output tcfd_pkg::cmd_t                    cmd_o
);
  import tcfd_pkg::*;

  localparam logic [SCOLS_W:0] MAXC = (SCOLS_W+1)'(MAX_COLS);
  localparam logic [SROWS_W:0] MAXR = (SROWS_W+1)'(MAX_ROWS);

  logic signed [POS_W-1:0] origin_q, origin_d;
  logic signed [CUR_W-1:0] ccol_q, ccol_d;
  logic signed [CUR_W-1:0] crow_q, crow_d;
  logic                    stop_q, stop_d;

  logic [SCOLS_W:0]        used_cols;
  logic [SROWS_W:0]        used_rows;
  logic signed [CUR_W-1:0] uc_s, ur_s;
  logic signed [CUR_W-1:0] px, py, xe, ye, x0, y0, x1, y1, xl, yl, crow_inc;
  logic                    scan_in, cur_in, rect_ok;

  assign used_cols = ({1'b0, screen_cols_i} < MAXC) ? {1'b0, screen_cols_i} : MAXC;
  assign used_rows = ({1'b0, screen_rows_i} < MAXR) ? {1'b0, screen_rows_i} : MAXR;
  assign uc_s      = $signed({1'b0, used_cols});
  assign ur_s      = $signed({2'b00, used_rows});

  assign px = {pos_x_i[POS_W-1], pos_x_i};
  assign py = {pos_y_i[POS_W-1], pos_y_i};

  assign scan_in = !px[CUR_W-1] && !py[CUR_W-1] && (px < uc_s) && (py < ur_s);
  assign cur_in  = !ccol_q[CUR_W-1] && !crow_q[CUR_W-1] && (ccol_q < uc_s) && (crow_q < ur_s);

  // clip the rectangle to [0, used) on both axes
  assign xe      = px + $signed({2'b00, rect_width_i});
  assign ye      = py + $signed({3'b000, rect_height_i});
  assign x0      = px[CUR_W-1] ? '0 : px;
  assign y0      = py[CUR_W-1] ? '0 : py;
  assign x1      = (xe < uc_s) ? xe : uc_s;
  assign y1      = (ye < ur_s) ? ye : ur_s;
  assign xl      = x1 - 10'sd1;
  assign yl      = y1 - 10'sd1;
  assign rect_ok = (x0 < x1) && (y0 < y1);

  assign crow_inc = crow_q + 10'sd1;

  always_comb begin
    origin_d       = origin_q;
    ccol_d         = ccol_q;
    crow_d         = crow_q;
    stop_d         = stop_q;
    push_o         = 1'b0;
    cmd_o.kind     = CMD_WR_CHAR;
    cmd_o.col      = ccol_q[COL_FW-1:0];
    cmd_o.row      = crow_q[ROW_FW-1:0];
    cmd_o.col_last = xl[COL_FW-1:0];
    cmd_o.row_last = yl[ROW_FW-1:0];
    cmd_o.glyph    = glyph_i;
    cmd_o.color    = paint_color_i;
    if (accept_i) begin
      unique case (op_i)
        OP_CLEAR: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_CLR_NEXT;
        end
        OP_ORIGIN: begin
          origin_d = pos_x_i;
          ccol_d   = px;
          crow_d   = py;
          stop_d   = 1'b0;
        end
        OP_TEXT: begin
          if (!stop_q) begin
            if (glyph_i == GLYPH_NEWLINE) begin
              ccol_d = {origin_q[POS_W-1], origin_q};
              crow_d = crow_inc;
              if (crow_inc >= ur_s) begin
                stop_d = 1'b1;
              end
            end else begin
              // space only moves the cursor
              push_o = (glyph_i != GLYPH_SPACE) && cur_in;
              if (ccol_q < CURSOR_MAX) begin
                ccol_d = ccol_q + 10'sd1;
              end
            end
          end
        end
        OP_RECT: begin
          push_o     = rect_ok;
          cmd_o.kind = CMD_RECT;
          cmd_o.col  = x0[COL_FW-1:0];
          cmd_o.row  = y0[ROW_FW-1:0];
        end
        OP_SCAN: begin
          push_o     = scan_in;
          cmd_o.kind = CMD_SCAN;
          cmd_o.col  = px[COL_FW-1:0];
          cmd_o.row  = py[ROW_FW-1:0];
        end
        OP_INVAL: begin
          push_o     = 1'b1;
          cmd_o.kind = CMD_CLR_SHOWN;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '0;
      ccol_q   <= '0;
      crow_q   <= '0;
      stop_q   <= 1'b0;
    end else begin
      origin_q <= origin_d;
      ccol_q   <= ccol_d;
      crow_q   <= crow_d;
      stop_q   <= stop_d;
    end
  end

endmodule

FILE: hdl/tcfd_queue.sv
// ----------------------------------------------------------------------------
// tcfd_queue: two-entry command queue
// Decouples operation decode from the cell engine so each side stalls alone.
// ----------------------------------------------------------------------------
module tcfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcfd_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output tcfd_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);
  import tcfd_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: hdl/tcfd_back.sv
// ----------------------------------------------------------------------------
// tcfd_back: cell engine
// Owns the next and shown frame stores. Executes one command at a time:
// character writes, rectangle color walks, cell scans and full-store sweeps.
// ----------------------------------------------------------------------------
module tcfd_back #(
  parameter int unsigned MAX_COLS = 128,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tcfd_pkg::cmd_t head_i,
  output logic           pop_o,
  output logic           init_o,
  output logic           res_valid_o,
  output tcfd_pkg::res_t res_o
);
  import tcfd_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned DEPTH = 2 ** AW;

  logic [GLYPH_W-1:0] nchar_mem  [DEPTH];
  logic [COLOR_W-1:0] ncolor_mem [DEPTH];
  logic [GLYPH_W-1:0] schar_mem  [DEPTH];
  logic [COLOR_W-1:0] scolor_mem [DEPTH];

  bk_state_e          state_q, state_d;
  sweep_t             sweep_q;
  logic [AW-1:0]      cnt_q;
  logic [CW-1:0]      x_q;
  logic [RW-1:0]      y_q;
  logic               init_q;
  cmd_t               cur_q;
  logic               out_valid_q;
  res_t               out_q;
  logic [GLYPH_W-1:0] nchar_rd_q, schar_rd_q;
  logic [COLOR_W-1:0] ncolor_rd_q, scolor_rd_q;

  logic [AW-1:0]      rd_addr, head_addr, cur_addr, rect_addr;
  logic               x_last, y_last, sweep_last, scan_diff;
  logic               nchar_we, ncolor_we, schar_we, scolor_we;
  logic [AW-1:0]      nchar_wa, ncolor_wa, schar_wa, scolor_wa;
  logic [GLYPH_W-1:0] nchar_wd, schar_wd;
  logic [COLOR_W-1:0] ncolor_wd, scolor_wd;

  assign head_addr  = {head_i.row[RW-1:0], head_i.col[CW-1:0]};
  assign cur_addr   = {cur_q.row[RW-1:0], cur_q.col[CW-1:0]};
  assign rect_addr  = {y_q, x_q};
  assign rd_addr    = head_addr;
  assign x_last     = (x_q == cur_q.col_last[CW-1:0]);
  assign y_last     = (y_q == cur_q.row_last[RW-1:0]);
  assign sweep_last = (cnt_q == '1);
  assign scan_diff  = (nchar_rd_q != schar_rd_q) || (ncolor_rd_q != scolor_rd_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          unique case (head_i.kind)
            CMD_RECT:                    state_d = ST_RECT;
            CMD_SCAN:                    state_d = ST_SCAN;
            CMD_CLR_NEXT, CMD_CLR_SHOWN: state_d = ST_SWEEP;
            default:                     state_d = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: if (sweep_last) state_d = ST_IDLE;
      ST_RECT:  if (x_last && y_last) state_d = ST_IDLE;
      ST_SCAN:  state_d = ST_IDLE;
    endcase
  end

  // outputs: queue pop and store write ports
  always_comb begin
    pop_o     = (state_q == ST_IDLE) && !empty_i;
    nchar_we  = 1'b0;
    ncolor_we = 1'b0;
    schar_we  = 1'b0;
    scolor_we = 1'b0;
    nchar_wa  = cnt_q;
    ncolor_wa = cnt_q;
    schar_wa  = cnt_q;
    scolor_wa = cnt_q;
    nchar_wd  = GLYPH_SPACE;
    ncolor_wd = COLOR_DEFAULT;
    // reset fill restores spaces, invalidate writes null characters
    schar_wd  = sweep_q.clr_shown_color ? GLYPH_SPACE : GLYPH_NULL;
    scolor_wd = COLOR_DEFAULT;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && (head_i.kind == CMD_WR_CHAR)) begin
          nchar_we = 1'b1;
          nchar_wa = head_addr;
          nchar_wd = head_i.glyph;
        end
      end
      ST_SWEEP: begin
        nchar_we  = sweep_q.clr_next;
        ncolor_we = sweep_q.clr_next;
        schar_we  = sweep_q.clr_shown_char;
        scolor_we = sweep_q.clr_shown_color;
      end
      ST_RECT: begin
        ncolor_we = 1'b1;
        ncolor_wa = rect_addr;
        ncolor_wd = cur_q.color;
      end
      ST_SCAN: begin
        schar_we  = scan_diff;
        scolor_we = scan_diff;
        schar_wa  = cur_addr;
        scolor_wa = cur_addr;
        schar_wd  = nchar_rd_q;
        scolor_wd = ncolor_rd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nchar_we) nchar_mem[nchar_wa] <= nchar_wd;
    nchar_rd_q <= nchar_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ncolor_we) ncolor_mem[ncolor_wa] <= ncolor_wd;
    ncolor_rd_q <= ncolor_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (schar_we) schar_mem[schar_wa] <= schar_wd;
    schar_rd_q <= schar_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (scolor_we) scolor_mem[scolor_wa] <= scolor_wd;
    scolor_rd_q <= scolor_mem[rd_addr];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    if ((state_q == ST_SCAN) && scan_diff) begin
      out_q.row   <= cur_q.row[OUT_ROW_W-1:0];
      out_q.col   <= cur_q.col[OUT_COL_W-1:0];
      out_q.color <= ncolor_rd_q;
      out_q.glyph <= nchar_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '{clr_next: 1'b1, clr_shown_char: 1'b1, clr_shown_color: 1'b1};
      cnt_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= (state_q == ST_SCAN) && scan_diff;
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            x_q   <= head_i.col[CW-1:0];
            y_q   <= head_i.row[RW-1:0];
            cnt_q <= '0;
            sweep_q <= '{clr_next:        (head_i.kind == CMD_CLR_NEXT),
                         clr_shown_char:  (head_i.kind == CMD_CLR_SHOWN),
                         clr_shown_color: 1'b0};
          end
        end
        ST_SWEEP: begin
          cnt_q <= cnt_q + AW'(1);
          if (sweep_last) begin
            init_q <= 1'b0;
          end
        end
        ST_RECT: begin
          // advance along the row, then wrap to the next row
          if (x_last) begin
            x_q <= cur_q.col[CW-1:0];
            y_q <= y_q + RW'(1);
          end else begin
            x_q <= x_q + CW'(1);
          end
        end
        ST_SCAN: begin
        end
      endcase
    end
  end

  assign init_o      = init_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

FILE: hdl/tcfd_checker.sv
// ----------------------------------------------------------------------------
// tcfd_checker: port-level checks for the text cell frame store
// Watches busy and result beats around reset and between scans.
// ----------------------------------------------------------------------------
module tcfd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic busy_o,
  input logic cell_valid_o
);

  // a scan reads the cell in the idle state and compares it in the scan state, so beats never abut
  a_beat_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid_o |=> !cell_valid_o)
    else $error("result beats in consecutive cycles");

  // the store clear after reset holds off new items
  a_busy_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> busy_o)
    else $error("busy low right after reset");

  a_quiet_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !cell_valid_o)
    else $error("result beat right after reset");

endmodule

bind text_cell_framebuffer_delta tcfd_checker u_tcfd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .busy_o       (busy_o),
  .cell_valid_o (cell_valid_o)
);
